[src/assert_macros.svh]
// Assertion macros used by the decoder's parse module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

`define ASSERT_IMPLIES(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: assertion failed");

`define ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(name, clk, rst, prop)
`define ASSERT_IMPLIES(name, clk, rst, pre, post)
`define ASSERT_NEXT(name, clk, rst, pre, post)

`endif

`endif

[src/bmpd_pkg.sv]
// Types and constants for the BMP 24-bit stream decoder.
package bmpd_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 2;
   localparam int ERR_W    = 4;
   localparam int COL_OUT_W = 12;
   localparam int ROW_OUT_W = 12;
   localparam int ADDR_W   = 26;
   localparam int DIM_W    = 13;
   localparam int WORD_W   = 32;

   localparam int RSP_DEPTH = 8;

   localparam logic [2:0] PH_WAIT = 3'd0;
   localparam logic [2:0] PH_HDR  = 3'd1;
   localparam logic [2:0] PH_SKIP = 3'd2;
   localparam logic [2:0] PH_PIX  = 3'd3;
   localparam logic [2:0] PH_PAD  = 3'd4;

   localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

   localparam logic [ERR_W-1:0] ERR_NONE        = 4'd0;
   localparam logic [ERR_W-1:0] ERR_MAGIC       = 4'd1;
   localparam logic [ERR_W-1:0] ERR_DIB_SIZE    = 4'd2;
   localparam logic [ERR_W-1:0] ERR_WIDTH       = 4'd3;
   localparam logic [ERR_W-1:0] ERR_HEIGHT      = 4'd4;
   localparam logic [ERR_W-1:0] ERR_PLANES      = 4'd5;
   localparam logic [ERR_W-1:0] ERR_BPP         = 4'd6;
   localparam logic [ERR_W-1:0] ERR_COMPRESSION = 4'd7;
   localparam logic [ERR_W-1:0] ERR_OFFSET      = 4'd8;
   localparam logic [ERR_W-1:0] ERR_TRUNCATED   = 4'd9;
   localparam logic [ERR_W-1:0] ERR_TOO_LARGE   = 4'd10;

   localparam logic [WORD_W-1:0] POS_MAGIC       = 32'd1;
   localparam logic [WORD_W-1:0] POS_OFFSET      = 32'd13;
   localparam logic [WORD_W-1:0] POS_DIB_SIZE    = 32'd17;
   localparam logic [WORD_W-1:0] POS_WIDTH       = 32'd21;
   localparam logic [WORD_W-1:0] POS_HEIGHT      = 32'd25;
   localparam logic [WORD_W-1:0] POS_PLANES      = 32'd27;
   localparam logic [WORD_W-1:0] POS_BPP         = 32'd29;
   localparam logic [WORD_W-1:0] POS_COMPRESSION = 32'd33;
   localparam logic [WORD_W-1:0] HDR_LEN         = 32'd54;
   localparam logic [WORD_W-1:0] HDR_LAST        = 32'd53;

   localparam logic [15:0]       MAGIC_BM     = 16'h4D42;
   localparam logic [WORD_W-1:0] MIN_DIB_SIZE = 32'd40;
   localparam logic [15:0]       PLANES_ONE   = 16'd1;
   localparam logic [15:0]       BPP_24       = 16'd24;

   typedef struct packed {
      logic [BYTE_W-1:0] file_byte;
      logic              first_of_file;
      logic              last_of_file;
   } bmpd_req_type;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [ERR_W-1:0]     error_code;
      logic [BYTE_W-1:0]    red;
      logic [BYTE_W-1:0]    green;
      logic [BYTE_W-1:0]    blue;
      logic [COL_OUT_W-1:0] column;
      logic [ROW_OUT_W-1:0] row;
      logic [ADDR_W-1:0]    byte_address;
      logic [DIM_W-1:0]     image_width;
      logic [DIM_W-1:0]     image_height;
      logic                 last_pixel;
   } bmpd_rsp_type;

   typedef struct packed {
      logic first;
      logic second;
   } bmpd_push_type;

endpackage

[src/bmpd_parse.sv]
// Header check, skip, pixel and padding parser; up to two results per byte.
`include "assert_macros.svh"

module bmpd_parse #(
   parameter int MAX_WIDTH  = bmpd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bmpd_pkg::DEF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  bmpd_pkg::bmpd_req_type in_data,
   output bmpd_pkg::bmpd_push_type push,
   output bmpd_pkg::bmpd_rsp_type  res0,
   output bmpd_pkg::bmpd_rsp_type  res1
);
   import bmpd_pkg::*;

   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = $clog2(MAX_HEIGHT + 1);
   localparam int WW1    = WW + 1;
   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int PROD_W = WW + HW;

   logic [2:0]        phase_ff,  phase_in;
   logic [WORD_W-1:0] pos_ff,    pos_in;
   logic [WORD_W-1:0] shift_ff,  shift_in;
   logic [WORD_W-1:0] offset_ff, offset_in;
   logic [WW-1:0]     width_ff,  width_in;
   logic [HW-1:0]     height_ff, height_in;
   logic [COL_W-1:0]  col_ff,    col_in;
   logic [ROW_W-1:0]  row_ff,    row_in;
   logic [1:0]        bip_ff,    bip_in;
   logic [1:0]        pad_ff,    pad_in;
   logic [7:0]        blue_ff,   blue_in;
   logic [7:0]        green_ff,  green_in;
   logic [ADDR_W-1:0] base_ff,   base_in;
   logic [ADDR_W-1:0] prod_ff,   prod_in;

   logic [HW-1:0]     height_m1;
   logic [PROD_W-1:0] prod_full;
   logic [ADDR_W-1:0] base_start;
   logic [ADDR_W-1:0] width3;
   logic [ADDR_W-1:0] col_ext;
   logic [ADDR_W-1:0] pix_addr;
   logic [WW1-1:0]    col_p1;
   logic              endcol;
   logic [ERR_W-1:0]  err;
   logic              hdr_ok;
   logic              pix;
   logic              trunc;
   logic              do_end_row;
   logic              last_pix;
   bmpd_rsp_type      r_hdr, r_pix, r_err;

   assign height_m1  = height_ff - HW'(1);
   assign prod_full  = PROD_W'(height_m1) * PROD_W'(width_ff);
   assign prod_in    = ADDR_W'(prod_full);
   assign base_start = prod_ff + (prod_ff << 1);
   assign width3     = ADDR_W'(width_ff) + (ADDR_W'(width_ff) << 1);
   assign col_ext    = ADDR_W'(col_ff);
   assign pix_addr   = base_ff + col_ext + (col_ext << 1);
   assign col_p1     = WW1'(col_ff) + WW1'(1);
   assign endcol     = (col_p1 >= WW1'(width_ff));

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      shift_in   = shift_ff;
      offset_in  = offset_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      bip_in     = bip_ff;
      pad_in     = pad_ff;
      blue_in    = blue_ff;
      green_in   = green_ff;
      base_in    = base_ff;
      err        = ERR_NONE;
      hdr_ok     = 1'b0;
      pix        = 1'b0;
      trunc      = 1'b0;
      do_end_row = 1'b0;
      last_pix   = 1'b0;
      if (in_valid) begin
         if (in_data.first_of_file) begin
            phase_in = PH_HDR;
            pos_in   = '0;
            shift_in = '0;
         end
         case (phase_in)
            PH_HDR: begin
               shift_in = {in_data.file_byte, shift_in[WORD_W-1:8]};
               case (pos_in)
                  POS_MAGIC: begin
                     if (shift_in[31:16] != MAGIC_BM) err = ERR_MAGIC;
                  end
                  POS_OFFSET: begin
                     offset_in = shift_in;
                     if (shift_in < HDR_LEN) err = ERR_OFFSET;
                  end
                  POS_DIB_SIZE: begin
                     if (shift_in < MIN_DIB_SIZE) err = ERR_DIB_SIZE;
                  end
                  POS_WIDTH: begin
                     width_in = WW'(shift_in);
                     if (shift_in == '0 || shift_in[31]) err = ERR_WIDTH;
                     else if (shift_in > WORD_W'(MAX_WIDTH)) err = ERR_TOO_LARGE;
                  end
                  POS_HEIGHT: begin
                     height_in = HW'(shift_in);
                     if (shift_in == '0 || shift_in[31]) err = ERR_HEIGHT;
                     else if (shift_in > WORD_W'(MAX_HEIGHT)) err = ERR_TOO_LARGE;
                  end
                  POS_PLANES: begin
                     if (shift_in[31:16] != PLANES_ONE) err = ERR_PLANES;
                  end
                  POS_BPP: begin
                     if (shift_in[31:16] != BPP_24) err = ERR_BPP;
                  end
                  POS_COMPRESSION: begin
                     if (shift_in != '0) err = ERR_COMPRESSION;
                  end
                  default: ;
               endcase
               if (err == ERR_NONE && pos_in == HDR_LAST) begin
                  hdr_ok   = 1'b1;
                  row_in   = ROW_W'(height_m1);
                  col_in   = '0;
                  bip_in   = '0;
                  pad_in   = '0;
                  base_in  = base_start;
                  phase_in = (offset_ff == HDR_LEN) ? PH_PIX : PH_SKIP;
               end
               pos_in = pos_in + WORD_W'(1);
            end
            PH_SKIP: begin
               pos_in = pos_ff + WORD_W'(1);
               if (pos_in >= offset_ff) phase_in = PH_PIX;
            end
            PH_PIX: begin
               case (bip_ff)
                  2'd0: begin
                     blue_in = in_data.file_byte;
                     bip_in  = 2'd1;
                  end
                  2'd1: begin
                     green_in = in_data.file_byte;
                     bip_in   = 2'd2;
                  end
                  default: begin
                     pix      = 1'b1;
                     last_pix = (row_ff == '0) && endcol;
                     bip_in   = 2'd0;
                     if (endcol) begin
                        pad_in = 2'(width_ff);
                        if (pad_in != 2'd0) phase_in = PH_PAD;
                        else do_end_row = 1'b1;
                     end else begin
                        col_in = col_ff + COL_W'(1);
                     end
                  end
               endcase
            end
            PH_PAD: begin
               if (pad_ff != 2'd0) pad_in = pad_ff - 2'd1;
               if (pad_in == 2'd0) do_end_row = 1'b1;
            end
            default: ;
         endcase
         if (do_end_row) begin
            if (row_ff == '0) begin
               phase_in = PH_WAIT;
            end else begin
               row_in   = row_ff - ROW_W'(1);
               base_in  = base_ff - width3;
               col_in   = '0;
               phase_in = PH_PIX;
            end
         end
         if (err != ERR_NONE) begin
            phase_in = PH_WAIT;
         end else if (in_data.last_of_file && phase_in != PH_WAIT) begin
            trunc    = 1'b1;
            phase_in = PH_WAIT;
         end
      end
   end

   always_comb begin
      r_hdr              = '0;
      r_hdr.kind         = KIND_HEADER;
      r_hdr.image_width  = DIM_W'(width_ff);
      r_hdr.image_height = DIM_W'(height_ff);

      r_pix              = '0;
      r_pix.kind         = KIND_PIXEL;
      r_pix.red          = in_data.file_byte;
      r_pix.green        = green_ff;
      r_pix.blue         = blue_ff;
      r_pix.column       = COL_OUT_W'(col_ff);
      r_pix.row          = ROW_OUT_W'(row_ff);
      r_pix.byte_address = pix_addr;
      r_pix.image_width  = DIM_W'(width_ff);
      r_pix.image_height = DIM_W'(height_ff);
      r_pix.last_pixel   = last_pix;

      r_err              = '0;
      r_err.kind         = KIND_ERROR;
      r_err.error_code   = trunc ? ERR_TRUNCATED : err;
   end

   assign push.first  = hdr_ok || pix || trunc || (err != ERR_NONE);
   assign push.second = (hdr_ok || pix) && (trunc || (err != ERR_NONE));
   assign res0        = hdr_ok ? r_hdr : (pix ? r_pix : r_err);
   assign res1        = r_err;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      shift_ff  <= shift_in;
      offset_ff <= offset_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      bip_ff    <= bip_in;
      pad_ff    <= pad_in;
      blue_ff   <= blue_in;
      green_ff  <= green_in;
      base_ff   <= base_in;
      prod_ff   <= prod_in;
   end

   `ASSERT_IMPLIES(a_second_needs_first, clock, reset, push.second, push.first)
   `ASSERT_IMPLIES(a_second_is_error, clock, reset, push.second, res1.kind == KIND_ERROR)
   `ASSERT_IMPLIES(a_pad_nonzero, clock, reset, phase_ff == PH_PAD, pad_ff != 2'd0)
   `ASSERT_IMPLIES(a_pixel_byte_range, clock, reset, phase_ff == PH_PIX, bip_ff != 2'd3)

endmodule

[src/bmpd_rsp_fifo.sv]
// Result queue: up to two writes and one read per cycle.
module bmpd_rsp_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  bmpd_pkg::bmpd_push_type push,
   input  bmpd_pkg::bmpd_rsp_type  wr0,
   input  bmpd_pkg::bmpd_rsp_type  wr1,
   input  logic                    pop,
   output logic                    not_empty,
   output bmpd_pkg::bmpd_rsp_type  rd_data,
   output logic [$clog2(bmpd_pkg::RSP_DEPTH+1)-1:0] count
);
   import bmpd_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   bmpd_rsp_type     mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [PTR_W-1:0] wr_ptr_p1;
   logic [1:0]       n_push;

   assign wr_ptr_p1 = wr_ptr_ff + PTR_W'(1);
   assign n_push    = 2'(push.first) + 2'(push.second);
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(n_push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         mem_ff[wr_ptr_ff] <= wr0;
      end
      if (push.second) begin
         mem_ff[wr_ptr_p1] <= wr1;
      end
   end

   assign not_empty = (count_ff != '0);
   assign rd_data   = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

[src/bmp24_stream_decoder.sv]
// Top level: one BMP byte per transaction in, header/pixel/error results out.
// The input stage register and then the result queue lie between a byte's transaction and its first result.
// Throughput: one byte per cycle while req_ready is high; a byte that gives two results takes two
// result transactions, set by the single read port of the result queue.
// Reset: synchronous, active high; waits for a first byte, queue emptied.
module bmp24_stream_decoder #(
   parameter int MAX_WIDTH  = bmpd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bmpd_pkg::DEF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bmpd_pkg::bmpd_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bmpd_pkg::bmpd_rsp_type rsp_data
);
   import bmpd_pkg::*;

   localparam int CNT_W = $clog2(RSP_DEPTH + 1);
   localparam int OCC_W = CNT_W + 1;

   logic          stage_valid_ff, stage_valid_in;
   bmpd_req_type  stage_ff;
   bmpd_push_type push;
   bmpd_rsp_type  res0, res1;
   logic [CNT_W-1:0] fifo_count;
   logic [OCC_W-1:0] occupancy;

   // reserve two queue entries for the byte in the stage and two for a new one
   assign occupancy      = OCC_W'(fifo_count) + (stage_valid_ff ? OCC_W'(2) : OCC_W'(0));
   assign req_ready      = (occupancy <= OCC_W'(RSP_DEPTH - 2));
   assign stage_valid_in = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid_in) begin
         stage_ff <= req_data;
      end
   end

   bmpd_parse #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .in_valid (stage_valid_ff),
      .in_data  (stage_ff),
      .push     (push),
      .res0     (res0),
      .res1     (res1)
   );

   bmpd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr0       (res0),
      .wr1       (res1),
      .pop       (rsp_valid && rsp_ready),
      .not_empty (rsp_valid),
      .rd_data   (rsp_data),
      .count     (fifo_count)
   );

endmodule
